// ===== hw/rtl/wcc_pkg.sv =====
// Shared constants, codes and program preset tables for the wash cycle controller.
package wcc_pkg;

    localparam int NUM_PROGRAMS = 7;
    localparam int NUM_EDITS    = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int OUT_W      = 43;
    localparam int OUT_BYTES_W = 48;

    localparam logic [2:0] CFG_REVERSAL_PERIOD = 3'd0;
    localparam logic [2:0] CFG_TIME_STEP       = 3'd1;
    localparam logic [2:0] CFG_SPEED_STEP      = 3'd2;
    localparam logic [2:0] CFG_TEMP_STEP       = 3'd3;
    localparam logic [2:0] CFG_MAX_TIME        = 3'd4;
    localparam logic [2:0] CFG_MAX_SPEED       = 3'd5;
    localparam logic [2:0] CFG_MAX_TEMP        = 3'd6;
    localparam logic [2:0] CFG_MAX_LEVEL       = 3'd7;

    localparam logic [2:0] EDIT_NONE  = 3'd0;
    localparam logic [2:0] EDIT_TIME  = 3'd1;
    localparam logic [2:0] EDIT_SPEED = 3'd2;
    localparam logic [2:0] EDIT_LEVEL = 3'd3;
    localparam logic [2:0] EDIT_TEMP  = 3'd4;

    localparam logic [1:0] DIR_CW  = 2'b01;
    localparam logic [1:0] DIR_CCW = 2'b11;

    localparam logic [5:0] RST_REVERSAL_PERIOD = 6'd5;
    localparam logic [6:0] RST_TIME_STEP       = 7'd5;
    localparam logic [6:0] RST_SPEED_STEP      = 7'd20;
    localparam logic [6:0] RST_TEMP_STEP       = 7'd5;
    localparam logic [6:0] RST_MAX_TIME        = 7'd99;
    localparam logic [6:0] RST_MAX_SPEED       = 7'd100;
    localparam logic [6:0] RST_MAX_TEMP        = 7'd80;
    localparam logic [3:0] RST_MAX_LEVEL       = 4'd5;

    typedef struct packed {
        logic [7:0] time_v;
        logic [7:0] speed_v;
        logic [3:0] level_v;
        logic [6:0] temp_v;
    } preset_t;

    function automatic preset_t program_preset(input logic [2:0] prog);
        preset_t p;
        case (prog)
            3'd1:    p = '{8'd20, 8'd80,  4'd2, 7'd25};
            3'd2:    p = '{8'd90, 8'd40,  4'd5, 7'd30};
            3'd3:    p = '{8'd80, 8'd100, 4'd4, 7'd30};
            3'd4:    p = '{8'd70, 8'd20,  4'd3, 7'd30};
            3'd5:    p = '{8'd50, 8'd60,  4'd4, 7'd45};
            3'd6:    p = '{8'd60, 8'd60,  4'd4, 7'd15};
            default: p = '{8'd60, 8'd60,  4'd3, 7'd25};
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/wash_cycle_controller.sv =====
// Wash cycle controller top level: key, encoder and tick handling with result register.
//
// Takes one transaction per clock while results are taken. Each accepted item is captured
// in an input register, the whole program/run/edit/clamp update (or the one-second tick
// update) is worked out in a single combinational pass against the state registers, and
// the result lands in the output register when that register is empty or being taken.
// The input register advances whenever the output register is empty or being taken, so
// throughput is one item per cycle; while a result waits the input side takes one more item
// into the input register and then stalls until the result is taken. Configuration registers
// are to be written through the cfg port only while no item is in flight; the block does not enforce it.
module wash_cycle_controller
    import wcc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] mode_key, [1] select_key, [3:2] direction, [7:4] zero
    input  logic [7:0]             s_axis_tdata,
    // [0] func
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] running, [3:1] program_res, [6:4] edited_setting, [14:7] time_left,
    // [22:15] set_speed, [30:23] motor_drive, [34:31] water_level,
    // [41:35] temperature, [42] blink_hidden, [47:43] zero
    output logic [OUT_BYTES_W-1:0] m_axis_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [5:0] reversal_period_reg;
    logic [6:0] time_step_reg;
    logic [6:0] speed_step_reg;
    logic [6:0] temp_step_reg;
    logic [6:0] max_time_reg;
    logic [6:0] max_speed_reg;
    logic [6:0] max_temp_reg;
    logic [3:0] max_level_reg;

    logic       in_valid_reg;
    logic       func_reg;
    logic       mode_reg;
    logic       select_reg;
    logic [1:0] dir_reg;

    logic [2:0]        program_reg, program_next;
    logic              run_reg, run_next;
    logic [2:0]        edit_reg, edit_next;
    logic signed [7:0] time_reg, time_next;
    logic signed [7:0] speed_reg, speed_next;
    logic [3:0]        level_reg, level_next;
    logic [6:0]        temp_reg, temp_next;
    logic [5:0]        rev_reg, rev_next;
    logic              blink_reg, blink_next;

    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic process;

    assign process       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || process;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_BYTES_W - OUT_W){1'b0}}, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reversal_period_reg <= RST_REVERSAL_PERIOD;
            time_step_reg       <= RST_TIME_STEP;
            speed_step_reg      <= RST_SPEED_STEP;
            temp_step_reg       <= RST_TEMP_STEP;
            max_time_reg        <= RST_MAX_TIME;
            max_speed_reg       <= RST_MAX_SPEED;
            max_temp_reg        <= RST_MAX_TEMP;
            max_level_reg       <= RST_MAX_LEVEL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REVERSAL_PERIOD: reversal_period_reg <= cfg_data[5:0];
                CFG_TIME_STEP:       time_step_reg       <= cfg_data;
                CFG_SPEED_STEP:      speed_step_reg      <= cfg_data;
                CFG_TEMP_STEP:       temp_step_reg       <= cfg_data;
                CFG_MAX_TIME:        max_time_reg        <= cfg_data;
                CFG_MAX_SPEED:       max_speed_reg       <= cfg_data;
                CFG_MAX_TEMP:        max_temp_reg        <= cfg_data;
                CFG_MAX_LEVEL:       max_level_reg       <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            func_reg   <= s_axis_tuser;
            mode_reg   <= s_axis_tdata[0];
            select_reg <= s_axis_tdata[1];
            dir_reg    <= s_axis_tdata[3:2];
        end
    end

    always_comb
    begin
        logic              dir_pos;
        logic              dir_neg;
        logic signed [9:0] time_w;
        logic signed [9:0] speed_w;
        logic signed [5:0] level_w;
        logic signed [8:0] temp_w;
        logic signed [9:0] tstep_w;
        logic signed [9:0] sstep_w;
        logic signed [8:0] pstep_w;
        logic signed [9:0] tmax_w;
        logic signed [9:0] smax_w;
        logic signed [8:0] pmax_w;
        logic signed [5:0] lmax_w;
        preset_t           pre;

        dir_pos = (dir_reg == DIR_CW);
        dir_neg = (dir_reg == DIR_CCW);
        tstep_w = $signed({3'b000, time_step_reg});
        sstep_w = $signed({3'b000, speed_step_reg});
        pstep_w = $signed({2'b00, temp_step_reg});
        tmax_w  = $signed({3'b000, max_time_reg});
        smax_w  = $signed({3'b000, max_speed_reg});
        pmax_w  = $signed({2'b00, max_temp_reg});
        lmax_w  = $signed({2'b00, max_level_reg});

        program_next = program_reg;
        run_next     = run_reg;
        edit_next    = edit_reg;
        rev_next     = rev_reg;
        blink_next   = blink_reg;
        time_w       = 10'(time_reg);
        speed_w      = 10'(speed_reg);
        level_w      = $signed({2'b00, level_reg});
        temp_w       = $signed({2'b00, temp_reg});
        pre          = program_preset(program_reg);

        if (func_reg)
        begin
            if (run_reg)
            begin
                if (time_w >= 0)
                begin
                    time_w = time_w - 10'sd1;
                end
                if (rev_reg <= 6'd1)
                begin
                    rev_next = reversal_period_reg;
                    speed_w  = -speed_w;
                end
                else
                begin
                    rev_next = rev_reg - 6'd1;
                end
            end
            blink_next = !blink_reg;
        end
        else
        begin
            if (mode_reg)
            begin
                program_next = (program_reg >= 3'(NUM_PROGRAMS - 1)) ? 3'd0
                                                                    : program_reg + 3'd1;
                pre     = program_preset(program_next);
                time_w  = $signed({2'b00, pre.time_v});
                speed_w = $signed({2'b00, pre.speed_v});
                level_w = $signed({2'b00, pre.level_v});
                temp_w  = $signed({2'b00, pre.temp_v});
            end

            if (select_reg)
            begin
                if (edit_reg == EDIT_NONE)
                begin
                    run_next = !run_reg;
                    if (!run_reg)
                    begin
                        rev_next = reversal_period_reg;
                    end
                end
                else
                begin
                    edit_next = (edit_reg >= 3'(NUM_EDITS - 1)) ? EDIT_NONE : edit_reg + 3'd1;
                end
            end
            if (edit_next == EDIT_NONE && dir_pos)
            begin
                edit_next = EDIT_TIME;
            end

            if (edit_next == EDIT_SPEED)
            begin
                if (dir_pos)
                begin
                    speed_w = (speed_w < 0) ? speed_w - sstep_w : speed_w + sstep_w;
                end
                else if (dir_neg)
                begin
                    if (speed_w < 0)
                    begin
                        speed_w = speed_w + sstep_w;
                    end
                    else if (speed_w > 0)
                    begin
                        speed_w = speed_w - sstep_w;
                    end
                end
            end
            if (speed_w > smax_w)
            begin
                speed_w = smax_w;
            end
            else if (speed_w < -smax_w)
            begin
                speed_w = -smax_w;
            end

            if (edit_next == EDIT_TIME)
            begin
                if (dir_pos)
                begin
                    time_w = time_w + tstep_w;
                end
                else if (dir_neg)
                begin
                    time_w = time_w - tstep_w;
                end
            end
            if (time_w < 0)
            begin
                time_w   = '0;
                run_next = 1'b0;
            end
            else if (time_w > tmax_w)
            begin
                time_w   = tmax_w;
                run_next = 1'b0;
            end

            if (edit_next == EDIT_TEMP)
            begin
                if (dir_pos)
                begin
                    temp_w = temp_w + pstep_w;
                end
                else if (dir_neg)
                begin
                    temp_w = temp_w - pstep_w;
                end
            end
            if (temp_w <= 0)
            begin
                temp_w = '0;
            end
            else if (temp_w > pmax_w)
            begin
                temp_w = pmax_w;
            end

            if (edit_next == EDIT_LEVEL)
            begin
                if (dir_pos)
                begin
                    level_w = level_w + 6'sd1;
                end
                else if (dir_neg)
                begin
                    level_w = level_w - 6'sd1;
                end
            end
            if (level_w <= 0)
            begin
                level_w = '0;
            end
            else if (level_w > lmax_w)
            begin
                level_w = lmax_w;
            end
        end

        time_next  = time_w[7:0];
        speed_next = speed_w[7:0];
        level_next = level_w[3:0];
        temp_next  = temp_w[6:0];

        out_data_next = {blink_next, temp_next, level_next,
                         (run_next ? speed_next : 8'sd0), speed_next, time_next,
                         edit_next, program_next, run_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_reg <= 3'd0;
            run_reg     <= 1'b0;
            edit_reg    <= EDIT_NONE;
            time_reg    <= 8'sd60;
            speed_reg   <= 8'sd60;
            level_reg   <= 4'd3;
            temp_reg    <= 7'd25;
            rev_reg     <= 6'd5;
            blink_reg   <= 1'b0;
        end
        else if (process)
        begin
            program_reg <= program_next;
            run_reg     <= run_next;
            edit_reg    <= edit_next;
            time_reg    <= time_next;
            speed_reg   <= speed_next;
            level_reg   <= level_next;
            temp_reg    <= temp_next;
            rev_reg     <= rev_next;
            blink_reg   <= blink_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_data_reg <= out_data_next;
        end
    end

    a_drive_off_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg[0] |-> out_data_reg[30:23] == 8'd0)
        else $error("motor drive non-zero while stopped");

    a_time_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        process && !func_reg |=> time_reg >= 0 && time_reg <= $signed({1'b0, max_time_reg}))
        else $error("time outside clamp after control pass");

    a_speed_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        process && !func_reg |=> 9'(speed_reg) <= $signed({2'b00, max_speed_reg})
                              && 9'(speed_reg) >= -$signed({2'b00, max_speed_reg}))
        else $error("speed outside clamp after control pass");

    a_edit_code: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> edit_reg <= EDIT_TEMP && program_reg <= 3'(NUM_PROGRAMS - 1))
        else $error("edit or program code out of range");

endmodule

// ===== tb/wash_cycle_controller_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the wash cycle controller: directed table, random phases, predictor.
module wash_cycle_controller_tb;
    import wcc_pkg::*;

    localparam logic [1:0] DIR_IDLE    = 2'b00;
    localparam logic [1:0] DIR_INVALID = 2'b10;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 235;
    localparam int HOLD_AT_ITEM    = 750;
    localparam int HOLD_CYCLES     = 300;

    localparam int PRESET_TIME  [NUM_PROGRAMS] = '{60, 20, 90, 80, 70, 50, 60};
    localparam int PRESET_SPEED [NUM_PROGRAMS] = '{60, 80, 40, 100, 20, 60, 60};
    localparam int PRESET_LEVEL [NUM_PROGRAMS] = '{3, 2, 5, 4, 3, 4, 4};
    localparam int PRESET_TEMP  [NUM_PROGRAMS] = '{25, 25, 30, 30, 30, 45, 15};

    typedef struct packed {
        logic       tick_item;
        logic       mode;
        logic       sel;
        logic [1:0] dir;
    } wash_item_t;

    // msb first: matches the output transaction layout from bit 42 down to bit 0
    typedef struct packed {
        logic       blink;
        logic [6:0] temp;
        logic [3:0] level;
        logic [7:0] motor;
        logic [7:0] speed;
        logic [7:0] time_left;
        logic [2:0] edit;
        logic [2:0] prog;
        logic       running;
    } wash_status_t;

    typedef struct packed {
        wash_item_t   item;
        logic         known;
        wash_status_t want;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_BYTES_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    wash_status_t pending_status [$];
    int           mismatches = 0;
    int           items_sent = 0;
    int           rx_wait = 0;
    bit           rx_hold = 1'b0;
    bit           idle_on = 1'b1;

    // predictor state
    int         cfg_val [8] = '{RST_REVERSAL_PERIOD, RST_TIME_STEP, RST_SPEED_STEP,
                                RST_TEMP_STEP, RST_MAX_TIME, RST_MAX_SPEED,
                                RST_MAX_TEMP, RST_MAX_LEVEL};
    int         prog_sel = 0;
    bit         run_on = 1'b0;
    logic [2:0] edit_field = EDIT_NONE;
    int         minutes_left = 60;
    int         speed_pct = 60;
    int         level_set = 3;
    int         temp_set = 25;
    int         reversal_left = 5;
    bit         blink_on = 1'b0;

    stim_row_t directed_rows [25] = '{
        '{'{1'b0, 1'b0, 1'b0, DIR_IDLE}, 1'b1,
          '{1'b0, 7'd25, 4'd3, 8'd0, 8'd60, 8'd60, EDIT_NONE, 3'd0, 1'b0}},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b1,
          '{1'b1, 7'd25, 4'd3, 8'd0, 8'd60, 8'd60, EDIT_NONE, 3'd0, 1'b0}},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b1,
          '{1'b1, 7'd25, 4'd2, 8'd0, 8'd80, 8'd20, EDIT_NONE, 3'd1, 1'b0}},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b1, 1'b0, DIR_IDLE}, 1'b0, '0},
        // keys on a tick are ignored
        '{'{1'b1, 1'b1, 1'b1, DIR_CW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, DIR_INVALID}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b1, 1'b0, 1'b0, DIR_IDLE}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, DIR_CW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, DIR_CCW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, DIR_CW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b0, DIR_CCW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, DIR_CCW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, DIR_CW}, 1'b0, '0},
        '{'{1'b0, 1'b0, 1'b1, DIR_IDLE}, 1'b0, '0}
    };

    wash_cycle_controller i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic wash_item_t draw_item();
        wash_item_t it;
        int         r;
        it.tick_item = ($urandom_range(0, 99) < 40);
        it.mode      = ($urandom_range(0, 99) < 8);
        it.sel       = ($urandom_range(0, 99) < 25);
        r = $urandom_range(0, 99);
        it.dir = (r < 35) ? DIR_CW : (r < 70) ? DIR_CCW : (r < 90) ? DIR_IDLE : DIR_INVALID;
        return it;
    endfunction

    // one-second tick or control pass, then the status word seen after the update
    task automatic advance_wash(input wash_item_t it, output wash_status_t st);
        int step;
        step = (it.dir == DIR_CW) ? 1 : (it.dir == DIR_CCW) ? -1 : 0;
        if (it.tick_item)
        begin
            if (run_on)
            begin
                if (minutes_left > -1)
                    minutes_left--;
                if (reversal_left <= 1)
                begin
                    reversal_left = cfg_val[CFG_REVERSAL_PERIOD];
                    speed_pct = -speed_pct;
                end
                else
                    reversal_left--;
            end
            blink_on = !blink_on;
        end
        else
        begin
            if (it.mode)
            begin
                prog_sel     = (prog_sel + 1 >= NUM_PROGRAMS) ? 0 : prog_sel + 1;
                minutes_left = PRESET_TIME[prog_sel];
                speed_pct    = PRESET_SPEED[prog_sel];
                level_set    = PRESET_LEVEL[prog_sel];
                temp_set     = PRESET_TEMP[prog_sel];
            end
            if (it.sel)
            begin
                if (edit_field == EDIT_NONE)
                begin
                    if (!run_on)
                    begin
                        run_on = 1'b1;
                        reversal_left = cfg_val[CFG_REVERSAL_PERIOD];
                    end
                    else
                        run_on = 1'b0;
                end
                else
                    edit_field = (edit_field == EDIT_TEMP) ? EDIT_NONE : edit_field + 3'd1;
            end
            if (edit_field == EDIT_NONE && step == 1)
                edit_field = EDIT_TIME;

            if (edit_field == EDIT_SPEED)
            begin
                if (step == 1)
                    speed_pct = (speed_pct < 0) ? speed_pct - cfg_val[CFG_SPEED_STEP]
                                                : speed_pct + cfg_val[CFG_SPEED_STEP];
                else if (step == -1 && speed_pct < 0)
                    speed_pct += cfg_val[CFG_SPEED_STEP];
                else if (step == -1 && speed_pct > 0)
                    speed_pct -= cfg_val[CFG_SPEED_STEP];
            end
            if (speed_pct > cfg_val[CFG_MAX_SPEED])
                speed_pct = cfg_val[CFG_MAX_SPEED];
            else if (speed_pct < -cfg_val[CFG_MAX_SPEED])
                speed_pct = -cfg_val[CFG_MAX_SPEED];

            if (edit_field == EDIT_TIME)
                minutes_left += step * cfg_val[CFG_TIME_STEP];
            if (minutes_left < 0)
            begin
                minutes_left = 0;
                run_on = 1'b0;
            end
            else if (minutes_left > cfg_val[CFG_MAX_TIME])
            begin
                minutes_left = cfg_val[CFG_MAX_TIME];
                run_on = 1'b0;
            end

            if (edit_field == EDIT_TEMP)
                temp_set += step * cfg_val[CFG_TEMP_STEP];
            if (temp_set <= 0)
                temp_set = 0;
            else if (temp_set > cfg_val[CFG_MAX_TEMP])
                temp_set = cfg_val[CFG_MAX_TEMP];

            if (edit_field == EDIT_LEVEL)
                level_set += step;
            if (level_set <= 0)
                level_set = 0;
            else if (level_set > cfg_val[CFG_MAX_LEVEL])
                level_set = cfg_val[CFG_MAX_LEVEL];
        end

        st.running   = run_on;
        st.prog      = prog_sel[2:0];
        st.edit      = edit_field;
        st.time_left = minutes_left[7:0];
        st.speed     = speed_pct[7:0];
        st.motor     = run_on ? speed_pct[7:0] : 8'd0;
        st.level     = level_set[3:0];
        st.temp      = temp_set[6:0];
        st.blink     = blink_on;
    endtask

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_status(input wash_status_t got);
        wash_status_t want;
        if (pending_status.size() == 0)
        begin
            report_mismatch("result transaction with nothing expected");
            return;
        end
        want = pending_status.pop_front();
        if (got.running !== want.running)
            report_mismatch($sformatf("running %0d, expected %0d", got.running, want.running));
        if (got.prog !== want.prog)
            report_mismatch($sformatf("program %0d, expected %0d", got.prog, want.prog));
        if (got.edit !== want.edit)
            report_mismatch($sformatf("edited setting %0d, expected %0d", got.edit, want.edit));
        if (got.time_left !== want.time_left)
            report_mismatch($sformatf("time left %0d, expected %0d",
                                      $signed(got.time_left), $signed(want.time_left)));
        if (got.speed !== want.speed)
            report_mismatch($sformatf("set speed %0d, expected %0d",
                                      $signed(got.speed), $signed(want.speed)));
        if (got.motor !== want.motor)
            report_mismatch($sformatf("motor drive %0d, expected %0d",
                                      $signed(got.motor), $signed(want.motor)));
        if (got.level !== want.level)
            report_mismatch($sformatf("water level %0d, expected %0d", got.level, want.level));
        if (got.temp !== want.temp)
            report_mismatch($sformatf("temperature %0d, expected %0d", got.temp, want.temp));
        if (got.blink !== want.blink)
            report_mismatch($sformatf("blink %0d, expected %0d", got.blink, want.blink));
    endtask

    // called on a rising edge; returns on the edge that accepts the transaction
    task automatic offer(input wash_item_t it, input logic known, input wash_status_t want);
        int           gap;
        wash_status_t predicted;
        gap = idle_on ? draw_gap() : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.tick_item;
        s_axis_tdata  <= {4'b0000, it.dir, it.sel, it.mode};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_wash(it, predicted);
        pending_status.push_back(known ? want : predicted);
        items_sent++;
    endtask

    task automatic apply_settings(input int vals [8]);
        for (int i = 0; i < 8; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[CFG_IDX_W-1:0];
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            cfg_val[i] = vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    always @(posedge clk)
    begin : rx_side
        int gap;
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_status(m_axis_tdata[OUT_W-1:0]);
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else if (rx_wait != 0)
        begin
            rx_wait       <= rx_wait - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            gap = idle_on ? draw_gap() : 0;
            m_axis_tready <= (gap == 0);
            rx_wait       <= (gap == 0) ? 0 : gap - 1;
        end
    end

    // long sink stall while the source keeps offering, to back the block up
    initial
    begin
        wait (items_sent >= HOLD_AT_ITEM);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #20ms;
        $display("wash_cycle_controller verification failed");
        $finish;
    end

    initial
    begin
        int vals [8];
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer(directed_rows[i].item, directed_rows[i].known, directed_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                s_axis_tvalid <= 1'b0;
                idle_on       <= (ph % 3 != 1);
                wait (pending_status.size() == 0);
                repeat (4) @(posedge clk);
                case (ph)
                    1: vals = '{1, 0, 0, 0, 1, 0, 0, 0};
                    2: vals = '{60, 99, 100, 80, 99, 100, 120, 15};
                    3: vals = '{0, 7, 30, 10, 30, 50, 60, 8};
                    7: vals = '{RST_REVERSAL_PERIOD, RST_TIME_STEP, RST_SPEED_STEP,
                                RST_TEMP_STEP, RST_MAX_TIME, RST_MAX_SPEED,
                                RST_MAX_TEMP, RST_MAX_LEVEL};
                    default:
                    begin
                        vals[CFG_REVERSAL_PERIOD] = ($urandom_range(0, 3) == 0) ?
                                                    $urandom_range(1, 60) : $urandom_range(1, 6);
                        vals[CFG_TIME_STEP]  = $urandom_range(0, 99);
                        vals[CFG_SPEED_STEP] = $urandom_range(0, 100);
                        vals[CFG_TEMP_STEP]  = $urandom_range(0, 80);
                        vals[CFG_MAX_TIME]   = $urandom_range(1, 99);
                        vals[CFG_MAX_SPEED]  = $urandom_range(0, 100);
                        vals[CFG_MAX_TEMP]   = $urandom_range(0, 120);
                        vals[CFG_MAX_LEVEL]  = $urandom_range(0, 15);
                    end
                endcase
                apply_settings(vals);
            end
            repeat (ITEMS_PER_PHASE)
                offer(draw_item(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        wait (pending_status.size() == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("wash_cycle_controller verification clean");
        else
            $display("wash_cycle_controller verification failed");
        $finish;
    end

endmodule
